// File: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert that a property holds at every rising clock edge out of reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Assert that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/dnl_pkg.sv
// Types, constants and helper functions of the DNS label encoder.
package dnl_pkg;

  localparam int MAX_LABEL_DEF  = 63;
  localparam int NAME_BYTES_DEF = 256;

  localparam int POS_W       = 13;
  localparam int ADDR_EXT_W  = 14;
  localparam int LEN_W       = 6;
  localparam int MAX_RESULTS = 8;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int IDX_W       = $clog2(MAX_RESULTS);
  localparam int LOCAL_LEN   = 5;

  localparam logic [POS_W-1:0] POS_MAX   = {POS_W{1'b1}};
  localparam logic [POS_W-1:0] POS_RESET = POS_W'(1);

  localparam logic       KIND_CHAR  = 1'b0;
  localparam logic       KIND_END   = 1'b1;
  localparam logic [7:0] CHAR_DOT   = 8'h2e;
  localparam logic [7:0] TERMINATOR = 8'h00;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [7:0] write_address;
    logic [7:0] write_byte;
    logic       last;
    logic       overflow;
  } out_item_t;

  typedef struct packed {
    logic [7:0] addr;
    logic [7:0] data;
  } wr_ent_t;

  typedef struct packed {
    wr_ent_t [MAX_RESULTS-1:0] ent;
    logic    [CNT_W-1:0]       count;
    logic                      overflow;
  } burst_t;

  // Characters of the appended local label.
  function automatic logic [7:0] local_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h6c;
      3'd1:    c = 8'h6f;
      3'd2:    c = 8'h63;
      3'd3:    c = 8'h61;
      3'd4:    c = 8'h6c;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/dnl_encoder.sv
// Name state, configuration register and per-item write list generation.
module dnl_encoder #(
  parameter int MAX_LABEL  = dnl_pkg::MAX_LABEL_DEF,
  parameter int NAME_BYTES = dnl_pkg::NAME_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              in_fire,
  input  dnl_pkg::in_item_t in_item,
  output dnl_pkg::burst_t   burst
);
  import dnl_pkg::*;

  localparam logic [LEN_W-1:0]      MAX_LEN   = LEN_W'(MAX_LABEL);
  localparam logic [ADDR_EXT_W-1:0] ADDR_LIM  = ADDR_EXT_W'(NAME_BYTES);

  logic [POS_W-1:0] wpos_r, wpos_nxt;
  logic [POS_W-1:0] slot_r, slot_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             trunc_r, trunc_nxt;
  logic             drop_r, drop_nxt;
  logic             local_r;

  logic [ADDR_EXT_W-1:0] cand_addr [MAX_RESULTS];
  logic [7:0]            cand_data [MAX_RESULTS];
  logic [CNT_W-1:0]      ncand;
  logic [MAX_RESULTS-1:0] keep;
  logic                  any_drop;
  logic [POS_W-1:0]      wpos_inc;

  assign wpos_inc = (wpos_r == POS_MAX) ? wpos_r : wpos_r + POS_W'(1);

  always_comb begin
    wpos_nxt  = wpos_r;
    slot_nxt  = slot_r;
    len_nxt   = len_r;
    trunc_nxt = trunc_r;
    ncand     = '0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      cand_addr[i] = '0;
      cand_data[i] = '0;
    end
    if (in_item.kind == KIND_CHAR) begin
      if (trunc_r) begin
        ncand = '0;
      end else if (in_item.char_code == CHAR_DOT) begin
        cand_addr[0] = {1'b0, slot_r};
        cand_data[0] = 8'(len_r);
        ncand        = CNT_W'(1);
        len_nxt      = '0;
        slot_nxt     = wpos_r;
        wpos_nxt     = wpos_inc;
      end else if (len_r >= MAX_LEN) begin
        trunc_nxt = 1'b1;
      end else begin
        cand_addr[0] = {1'b0, wpos_r};
        cand_data[0] = in_item.char_code;
        ncand        = CNT_W'(1);
        len_nxt      = len_r + LEN_W'(1);
        wpos_nxt     = wpos_inc;
      end
    end else begin
      cand_addr[0] = {1'b0, slot_r};
      cand_data[0] = 8'(len_r);
      if (local_r) begin
        cand_addr[1] = {1'b0, wpos_r};
        cand_data[1] = 8'(LOCAL_LEN);
        for (int k = 0; k < LOCAL_LEN; k++) begin
          cand_addr[k+2] = {1'b0, wpos_r} + ADDR_EXT_W'(k + 1);
          cand_data[k+2] = local_char(3'(k));
        end
        cand_addr[LOCAL_LEN+2] = {1'b0, wpos_r} + ADDR_EXT_W'(LOCAL_LEN + 1);
        cand_data[LOCAL_LEN+2] = TERMINATOR;
        ncand = CNT_W'(LOCAL_LEN + 3);
      end else begin
        cand_addr[1] = {1'b0, wpos_r};
        cand_data[1] = TERMINATOR;
        ncand        = CNT_W'(2);
      end
      wpos_nxt  = POS_RESET;
      slot_nxt  = '0;
      len_nxt   = '0;
      trunc_nxt = 1'b0;
    end
  end

  // Addresses rise within an item, so the kept writes always form a prefix.
  always_comb begin
    any_drop = 1'b0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      keep[i]  = (CNT_W'(i) < ncand) && (cand_addr[i] < ADDR_LIM);
      any_drop = any_drop | ((CNT_W'(i) < ncand) && (cand_addr[i] >= ADDR_LIM));
      burst.ent[i].addr = cand_addr[i][7:0];
      burst.ent[i].data = cand_data[i];
    end
    drop_nxt       = drop_r | any_drop;
    burst.count    = CNT_W'($countones(keep));
    burst.overflow = drop_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wpos_r  <= POS_RESET;
      slot_r  <= '0;
      len_r   <= '0;
      trunc_r <= 1'b0;
      drop_r  <= 1'b0;
      local_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        local_r <= cfg_wdata;
      end
      if (in_fire) begin
        wpos_r  <= wpos_nxt;
        slot_r  <= slot_nxt;
        len_r   <= len_nxt;
        trunc_r <= trunc_nxt;
        drop_r  <= drop_nxt;
      end
    end
  end

endmodule

// File: rtl/dnl_burst_out.sv
// Result register that holds one item's writes and hands them out one per cycle while out_ready is high.
module dnl_burst_out (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  dnl_pkg::burst_t    burst,
  input  logic               out_ready,
  output logic               out_valid,
  output dnl_pkg::out_item_t out_item,
  output logic               in_ready
);
  import dnl_pkg::*;

  wr_ent_t [MAX_RESULTS-1:0] ent_r;
  logic    [CNT_W-1:0]       rem_r;
  logic    [IDX_W-1:0]       idx_r;
  logic                      ovf_r;
  logic                      out_fire;

  assign out_valid = (rem_r != '0);
  assign out_fire  = out_valid && out_ready;
  assign in_ready  = (rem_r == '0) || ((rem_r == CNT_W'(1)) && out_ready);

  assign out_item.write_address = ent_r[idx_r].addr;
  assign out_item.write_byte    = ent_r[idx_r].data;
  assign out_item.last          = (rem_r == CNT_W'(1));
  assign out_item.overflow      = ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      idx_r <= '0;
    end else if (load && (burst.count != '0)) begin
      rem_r <= burst.count;
      idx_r <= '0;
    end else if (out_fire) begin
      rem_r <= rem_r - CNT_W'(1);
      idx_r <= idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load && (burst.count != '0)) begin
      ent_r <= burst.ent;
      ovf_r <= burst.overflow;
    end
  end

endmodule

// File: rtl/dotted_name_to_dns_labels.sv
// The first write of an item appears in the cycle after the item is taken.
// An item producing n writes (n is 0 to 8) holds the output until all n are taken;
// the next item is taken in the cycle the final write of the previous one is taken.
// Name characters give at most one write; with out_ready high they stream one item per cycle.
// Reset (synchronous, active low) sets the write position to one and clears the rest
// of the name state, the overflow flag, the configuration register and the result count.
module dotted_name_to_dns_labels #(
  parameter int MAX_LABEL  = dnl_pkg::MAX_LABEL_DEF,
  parameter int NAME_BYTES = dnl_pkg::NAME_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  dnl_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output dnl_pkg::out_item_t out_item
);
  import dnl_pkg::*;
  `include "assert_macros.svh"

  logic   in_fire;
  burst_t burst;

  assign in_fire = in_valid && in_ready;

  dnl_encoder #(
    .MAX_LABEL  (MAX_LABEL),
    .NAME_BYTES (NAME_BYTES)
  ) u_encoder (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_fire   (in_fire),
    .in_item   (in_item),
    .burst     (burst)
  );

  dnl_burst_out u_burst_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_fire),
    .burst     (burst),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_item),
    .in_ready  (in_ready)
  );

  `ASSERT_PROP(a_no_take_mid_burst, clk, rst_n, (out_valid && !out_item.last) |-> !in_ready)
  `ASSERT_NEXT(a_burst_continues, clk, rst_n, out_valid && out_ready && !out_item.last, out_valid)
  `ASSERT_NEXT(a_overflow_sticky, clk, rst_n, out_valid && out_ready && out_item.overflow, !out_valid || out_item.overflow)

endmodule

// File: tb/sv/dotted_name_to_dns_labels_test.sv
// Self-checking testbench of the DNS label encoder with an encoding predictor and random names.
`timescale 1ns / 1ps

module dotted_name_to_dns_labels_test;
  import dnl_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 30;
  localparam logic [39:0] LOCAL_TEXT = "local";

  class encoded_name_writes;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] slot;
    logic [LEN_W-1:0] label_len;
    bit truncated;
    bit dropped;
    bit append_local;
    out_item_t pending_writes[$];
    out_item_t burst[$];
    int failures;

    function new();
      clear_name();
      dropped = 1'b0;
      append_local = 1'b0;
      failures = 0;
    endfunction

    function void clear_name();
      position = POS_RESET;
      slot = '0;
      label_len = '0;
      truncated = 1'b0;
    endfunction

    function void advance();
      if (position != POS_MAX) position++;
    endfunction

    function void emit(int unsigned addr, logic [7:0] data);
      out_item_t w;
      if (addr >= NAME_BYTES_DEF) begin
        dropped = 1'b1;
        return;
      end
      w.write_address = addr[7:0];
      w.write_byte = data;
      w.last = 1'b0;
      w.overflow = 1'b0;
      burst.push_back(w);
    endfunction

    function void encode_item(in_item_t it);
      int unsigned p;
      burst = {};
      if (it.kind == KIND_CHAR) begin
        if (truncated) begin
          // The rest of an overlong name is ignored.
        end else if (it.char_code == CHAR_DOT) begin
          emit(slot, 8'(label_len));
          label_len = '0;
          slot = position;
          advance();
        end else if (label_len >= MAX_LABEL_DEF) begin
          truncated = 1'b1;
        end else begin
          emit(position, it.char_code);
          label_len++;
          advance();
        end
      end else begin
        p = position;
        emit(slot, 8'(label_len));
        if (append_local) begin
          emit(p, 8'(LOCAL_LEN));
          p++;
          for (int k = 0; k < LOCAL_LEN; k++) begin
            emit(p, LOCAL_TEXT[39 - 8 * k -: 8]);
            p++;
          end
        end
        emit(p, TERMINATOR);
        clear_name();
      end
      foreach (burst[k]) begin
        burst[k].last = (k == burst.size() - 1);
        burst[k].overflow = dropped;
        pending_writes.push_back(burst[k]);
      end
    endfunction

    function void match_write(out_item_t got);
      out_item_t want;
      if (pending_writes.size() == 0) begin
        $error("unexpected write: address %0d, byte %0d", got.write_address, got.write_byte);
        failures++;
        return;
      end
      want = pending_writes.pop_front();
      if (got.write_address !== want.write_address) begin
        $error("write_address: expected %0d, actual %0d", want.write_address, got.write_address);
        failures++;
      end
      if (got.write_byte !== want.write_byte) begin
        $error("write_byte: expected %0d, actual %0d", want.write_byte, got.write_byte);
        failures++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last);
        failures++;
      end
      if (got.overflow !== want.overflow) begin
        $error("overflow: expected %0d, actual %0d", want.overflow, got.overflow);
        failures++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;

  encoded_name_writes writes;
  int idle_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;
  int quiet_cycles = 0;

  dotted_name_to_dns_labels i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) writes.append_local = cfg_wdata;
      if (in_valid && in_ready) writes.encode_item(in_item);
      if (out_valid && out_ready) writes.match_write(out_item);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(logic kind, logic [7:0] code);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{kind: kind, char_code: code};
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_label_char();
    logic [7:0] code;
    do code = 8'($urandom_range(255)); while (code == CHAR_DOT);
    send_item(KIND_CHAR, code);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (writes.pending_writes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_append_local(logic value);
    wait_drained();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_random_name();
    int labels;
    int len;
    labels = $urandom_range(1, 4);
    for (int l = 0; l < labels; l++) begin
      if (l > 0) send_item(KIND_CHAR, CHAR_DOT);
      len = ($urandom_range(99) < 6) ? $urandom_range(60, 70) : $urandom_range(0, 8);
      repeat (len) send_label_char();
    end
    if ($urandom_range(99) < 10) send_item(KIND_CHAR, CHAR_DOT);
    send_item(KIND_END, 8'($urandom_range(255)));
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 4)) begin
      send_item(($urandom_range(99) < 25) ? KIND_END : KIND_CHAR, 8'($urandom_range(255)));
    end
  endtask

  // Five full labels run past the end of the buffer, so later writes are dropped.
  task automatic send_long_name();
    for (int l = 0; l < 5; l++) begin
      if (l > 0) send_item(KIND_CHAR, CHAR_DOT);
      repeat (MAX_LABEL_DEF) send_label_char();
    end
    send_item(KIND_CHAR, CHAR_DOT);
    repeat (3) send_label_char();
    send_item(KIND_END, 8'h00);
  endtask

  initial begin
    int sender_idle[4];
    int receiver_stall[4];
    logic phase_local[4];
    int target;
    sender_idle = '{0, 81, 0, 28};
    receiver_stall = '{0, 0, 81, 28};
    phase_local = '{1'b1, 1'b0, 1'b1, 1'b1};
    writes = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_append_local(1'b0);
    send_item(KIND_CHAR, 8'h00);
    send_item(KIND_CHAR, 8'hff);
    send_item(KIND_END, 8'hab);
    send_item(KIND_CHAR, CHAR_DOT);
    send_item(KIND_CHAR, 8'h78);
    send_item(KIND_CHAR, CHAR_DOT);
    send_item(KIND_CHAR, CHAR_DOT);
    send_item(KIND_END, 8'h00);
    set_append_local(1'b1);
    send_item(KIND_CHAR, 8'h5a);
    send_item(KIND_END, 8'hff);
    send_item(KIND_END, 8'h00);
    send_item(KIND_CHAR, 8'h7f);
    send_item(KIND_CHAR, CHAR_DOT);
    send_item(KIND_END, 8'h55);

    for (int ph = 0; ph < 4; ph++) begin
      set_append_local(phase_local[ph]);
      idle_pct = sender_idle[ph];
      stall_pct = receiver_stall[ph];
      target = items_sent + ITEMS_PER_PHASE;
      while (items_sent < target) begin
        if ($urandom_range(99) < 12) send_noise();
        else send_random_name();
      end
      if (ph == 3) begin
        send_item(KIND_END, 8'h00);
        send_long_name();
        send_random_name();
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (writes.failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/dnl_pkg.sv
rtl/dnl_encoder.sv
rtl/dnl_burst_out.sv
rtl/dotted_name_to_dns_labels.sv
tb/sv/dotted_name_to_dns_labels_test.sv
